/* sv/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the LZW decoder
// Code values, phases, default sizes and the controller/datapath links.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int DEF_MAX_CODE_WIDTH  = 11;
  localparam int DEF_TABLE_DEPTH     = 2048;
  localparam int DEF_EXPANSION_LIMIT = 4000;
  localparam int DEF_STACK_DEPTH     = 4096;

  localparam int MAX_OUT = 64;

  localparam logic [4:0]  START_WIDTH  = 5'd9;
  localparam logic [15:0] CODE_MASK    = 16'h7FFF;
  localparam logic [15:0] CODE_RESTART = 16'h0100;
  localparam logic [15:0] CODE_END     = 16'h0101;
  localparam logic [16:0] NEXT_RESET   = 17'd257;
  localparam logic [16:0] NEXT_RESTART = 17'd258;
  localparam logic [16:0] NEXT_CAP     = 17'h1FFFF;
  localparam logic [15:0] LEN_RESET    = 16'hFFFF;

  localparam logic [1:0] PH_FIRST         = 2'd0;
  localparam logic [1:0] PH_NORMAL        = 2'd1;
  localparam logic [1:0] PH_AFTER_RESTART = 2'd2;
  localparam logic [1:0] PH_DONE          = 2'd3;

  typedef struct packed {
    logic load_in;
    logic extract;
    logic take;
    logic cnt_step;
    logic size;
    logic fit;
    logic fill_step;
    logic root_wr;
    logic kw_wr;
    logic update;
    logic emit_status;
    logic emit_byte;
  } cmd_t;

  typedef struct packed {
    logic can_extract;
    logic need_decode;
    logic chain_more;
    logic fit_ok;
    logic fill_more;
    logic q_empty;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

/* sv/lzwd_in_if.sv */
// ----------------------------------------------------------------------------
// lzwd_in_if: compressed byte channel
// Valid/ready channel carrying one compressed byte per beat.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_stream;

  modport source (output valid, output in_byte, output first_of_stream, input ready);
  modport sink (input valid, input in_byte, input first_of_stream, output ready);
endinterface

/* sv/lzwd_out_if.sv */
// ----------------------------------------------------------------------------
// lzwd_out_if: decoded byte channel
// Valid/ready channel carrying one decoded byte or status beat.
// ----------------------------------------------------------------------------
interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       finished;
  logic       expansion_error;

  modport source (output valid, output out_byte, output has_byte, output last_of_run,
                  output finished, output expansion_error, input ready);
  modport sink (input valid, input out_byte, input has_byte, input last_of_run,
                input finished, input expansion_error, output ready);
endinterface

/* sv/lzw_variable_width_decoder_core.sv */
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_core: variable-width LZW decompressor
// Unpacks 9..MAX_CODE_WIDTH bit codes and expands them into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one compressed byte per beat; first_of_stream restarts the
//   stream (bit buffer, dictionary state, counters, pending bytes).
//   dout carries the results of each accepted byte: every decoded byte that
//   is pending, at most 64 per input byte, or one status beat with has_byte
//   low when nothing is pending. last_of_run marks the final beat of a run.
//   cfg_wr_en/cfg_wr_data write output_length; write only while idle.
// Timing:
//   A code is expanded by counting its chain of table steps, one prefix-table
//   read per cycle, then a second walk that writes the string into the
//   output queue, then table update. Output beats are paced by the
//   registered read of the queue memory.
// Reset and stall:
//   rst clears control state; tables and queue hold no valid data until
//   written. A stalled dout holds the current beat in the output register;
//   din is accepted again once the last beat of a run is loaded there.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_core #(
  parameter int MAX_CODE_WIDTH  = lzwd_pkg::DEF_MAX_CODE_WIDTH,
  parameter int TABLE_DEPTH     = lzwd_pkg::DEF_TABLE_DEPTH,
  parameter int EXPANSION_LIMIT = lzwd_pkg::DEF_EXPANSION_LIMIT,
  parameter int STACK_DEPTH     = lzwd_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  lzwd_in_if.sink     din,
  lzwd_out_if.source  dout,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  lzwd_pkg::cmd_t    cmd;
  lzwd_pkg::status_t st;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lzwd_dp #(
    .MAX_CODE_WIDTH  (MAX_CODE_WIDTH),
    .TABLE_DEPTH     (TABLE_DEPTH),
    .EXPANSION_LIMIT (EXPANSION_LIMIT),
    .STACK_DEPTH     (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_byte         (din.in_byte),
    .first_of_stream (din.first_of_stream),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (dout.valid),
    .out_ready       (dout.ready),
    .out_byte        (dout.out_byte),
    .has_byte        (dout.has_byte),
    .last_of_run     (dout.last_of_run),
    .finished        (dout.finished),
    .expansion_error (dout.expansion_error)
  );

endmodule

/* sv/lzwd_ctrl.sv */
// ----------------------------------------------------------------------------
// lzwd_ctrl: decoder sequencer
// Steps each input byte through code extraction, chain walks, queue
// writes and the output run.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lzwd_pkg::status_t st,
  output lzwd_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_TAKE  = 4'd2;
  localparam logic [3:0] S_CNT   = 4'd3;
  localparam logic [3:0] S_FIT   = 4'd4;
  localparam logic [3:0] S_FILL  = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_KW    = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_EWAIT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.can_extract) begin
          cmd.extract = 1'b1;
          state_next = S_TAKE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        state_next = st.need_decode ? S_CNT : S_CHECK;
      end
      S_CNT: begin
        if (st.chain_more) begin
          cmd.cnt_step = 1'b1;
        end else begin
          cmd.size = 1'b1;
          state_next = S_FIT;
        end
      end
      S_FIT: begin
        cmd.fit = 1'b1;
        state_next = st.fit_ok ? S_FILL : S_CHECK;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (!st.fill_more) state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_wr = 1'b1;
        state_next = S_KW;
      end
      S_KW: begin
        cmd.kw_wr = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_CHECK;
      end
      S_EMIT: begin
        if (st.out_free) begin
          if (st.q_empty) begin
            cmd.emit_status = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.emit_byte = 1'b1;
            state_next = st.emit_last ? S_IDLE : S_EWAIT;
          end
        end
      end
      S_EWAIT: state_next = S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/lzwd_dp.sv */
// ----------------------------------------------------------------------------
// lzwd_dp: decoder datapath
// Bit buffer, code tables, output queue, stream registers and the output
// register, driven by strobes from the sequencer.
// ----------------------------------------------------------------------------
module lzwd_dp #(
  parameter int MAX_CODE_WIDTH  = lzwd_pkg::DEF_MAX_CODE_WIDTH,
  parameter int TABLE_DEPTH     = lzwd_pkg::DEF_TABLE_DEPTH,
  parameter int EXPANSION_LIMIT = lzwd_pkg::DEF_EXPANSION_LIMIT,
  parameter int STACK_DEPTH     = lzwd_pkg::DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  lzwd_pkg::cmd_t     cmd,
  output lzwd_pkg::status_t  st,
  input  logic [7:0]        in_byte,
  input  logic              first_of_stream,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              has_byte,
  output logic              last_of_run,
  output logic              finished,
  output logic              expansion_error
);

  localparam int CW  = MAX_CODE_WIDTH;
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int QAW = $clog2(STACK_DEPTH);
  localparam int QCW = $clog2(STACK_DEPTH + 1);
  localparam int SW  = $clog2(EXPANSION_LIMIT + 2);
  localparam int KW  = $clog2(lzwd_pkg::MAX_OUT);

  // stores
  logic [CW-1:0] pmem [TABLE_DEPTH];
  logic [7:0]    smem [TABLE_DEPTH];
  logic [7:0]    qmem [STACK_DEPTH];

  // stream state
  logic [15:0]    output_length;
  logic [31:0]    bit_buf;
  logic [5:0]     bit_count;
  logic [4:0]     code_width;
  logic [16:0]    next_code;
  logic [CW-1:0]  prev_code;
  logic [7:0]     first_char;
  logic [15:0]    emitted;
  logic [1:0]     phase;
  logic           err;
  logic [QAW-1:0] q_head;
  logic [QCW-1:0] q_count;
  logic [KW-1:0]  k;

  // per-code work registers
  logic [CW-1:0]  code;
  logic           kw;
  logic [CW-1:0]  start_code;
  logic           sel_start;
  logic [SW-1:0]  steps;
  logic [SW-1:0]  pos;
  logic [7:0]     root;
  logic           over;
  logic [16:0]    len;
  logic [15:0]    n;
  logic [QAW-1:0] tail;
  logic           wr_pend;
  logic [SW-1:0]  wr_pos;

  // memory read data
  logic [CW-1:0]  prefix_q;
  logic [7:0]     suffix_q;
  logic           oob_q;
  logic [7:0]     q_rd;

  function automatic logic [QAW-1:0] qwrap(input logic [17:0] a, input logic [17:0] b);
    logic [17:0] s;
    s = a + b;
    if (s >= 18'(STACK_DEPTH)) s = s - 18'(STACK_DEPTH);
    return s[QAW-1:0];
  endfunction

  // chain walk value and table address
  logic [CW-1:0]  cur;
  logic [17:0]    cur_x;
  logic [TAW-1:0] taddr;
  logic [17:0]    next_x;
  logic           tw_en;

  assign cur    = sel_start ? start_code : (oob_q ? '0 : prefix_q);
  assign cur_x  = 18'(cur);
  assign taddr  = cur_x[TAW-1:0];
  assign next_x = 18'(next_code);
  assign tw_en  = cmd.update && (next_x < 18'(TABLE_DEPTH));

  // code extraction
  logic [16:0] wmask;
  logic [15:0] code_w;
  assign wmask  = (17'd1 << code_width) - 17'd1;
  assign code_w = bit_buf[15:0] & wmask[15:0] & lzwd_pkg::CODE_MASK;

  logic emitted_done;
  logic code_is_end;
  logic code_is_restart;
  assign emitted_done    = emitted >= output_length;
  assign code_is_end     = 16'(code) == lzwd_pkg::CODE_END;
  assign code_is_restart = 16'(code) == lzwd_pkg::CODE_RESTART;

  // sizing
  logic [15:0]    room;
  logic [16:0]    len_c;
  logic [15:0]    n_c;
  logic [QCW-1:0] q_free;
  logic [16:0]    len_m1;
  logic           push_ok;
  assign room    = output_length - emitted;
  assign len_c   = 17'(steps) + 17'd1 + 17'(kw);
  assign n_c     = (len_c < 17'(room)) ? len_c[15:0] : room;
  assign q_free  = QCW'(STACK_DEPTH) - q_count;
  assign len_m1  = len - 17'd1;
  assign push_ok = (phase == lzwd_pkg::PH_AFTER_RESTART) && !emitted_done &&
                   (q_count < QCW'(STACK_DEPTH));

  // status
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    st = '0;
    st.can_extract = (phase != lzwd_pkg::PH_DONE) && (bit_count >= 6'(code_width));
    st.need_decode = (phase == lzwd_pkg::PH_NORMAL) && !emitted_done &&
                     !code_is_end && !code_is_restart;
    st.chain_more  = (cur_x > 18'd255) && (18'(steps) <= 18'(EXPANSION_LIMIT));
    st.fit_ok      = !over && (18'(n) <= 18'(q_free));
    st.fill_more   = pos != '0;
    st.q_empty     = q_count == '0;
    st.emit_last   = (k == KW'(lzwd_pkg::MAX_OUT - 1)) || (q_count == QCW'(1));
    st.out_free    = out_free;
  end

  // queue write port
  logic           qw_en;
  logic [QAW-1:0] qw_addr;
  logic [7:0]     qw_data;

  always_comb begin
    qw_en   = 1'b0;
    qw_addr = tail;
    qw_data = root;
    priority if (wr_pend) begin
      qw_en   = 1'b1;
      qw_addr = qwrap(18'(tail), 18'(wr_pos));
      qw_data = oob_q ? 8'd0 : suffix_q;
    end else if (cmd.root_wr) begin
      qw_en = 1'b1;
    end else if (cmd.kw_wr && kw && (18'(len_m1) < 18'(n))) begin
      qw_en   = 1'b1;
      qw_addr = qwrap(18'(tail), 18'(len_m1));
      qw_data = first_char;
    end else if (cmd.take && push_ok) begin
      qw_en   = 1'b1;
      qw_addr = qwrap(18'(q_head), 18'(q_count));
      qw_data = code[7:0];
    end else begin
      qw_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      pmem[next_x[TAW-1:0]] <= prev_code;
      smem[next_x[TAW-1:0]] <= root;
    end
    prefix_q <= pmem[taddr];
    suffix_q <= smem[taddr];
    oob_q    <= cur_x >= 18'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (qw_en) qmem[qw_addr] <= qw_data;
    q_rd <= qmem[q_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= lzwd_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      output_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf    <= '0;
      bit_count  <= '0;
      code_width <= lzwd_pkg::START_WIDTH;
      next_code  <= lzwd_pkg::NEXT_RESET;
      prev_code  <= '0;
      first_char <= '0;
      emitted    <= '0;
      phase      <= lzwd_pkg::PH_FIRST;
      err        <= 1'b0;
      q_head     <= '0;
      q_count    <= '0;
      k          <= '0;
      sel_start  <= 1'b1;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      wr_pend <= 1'b0;
      if (out_ready) out_valid <= 1'b0;

      if (cmd.load_in) begin
        k <= '0;
        if (first_of_stream) begin
          bit_buf    <= 32'(in_byte);
          bit_count  <= 6'd8;
          code_width <= lzwd_pkg::START_WIDTH;
          next_code  <= lzwd_pkg::NEXT_RESET;
          prev_code  <= '0;
          first_char <= '0;
          emitted    <= '0;
          phase      <= lzwd_pkg::PH_FIRST;
          err        <= 1'b0;
          q_head     <= '0;
          q_count    <= '0;
        end else if (phase != lzwd_pkg::PH_DONE) begin
          bit_buf   <= bit_buf | (32'(in_byte) << bit_count);
          bit_count <= bit_count + 6'd8;
        end
      end

      if (cmd.extract) begin
        code      <= code_w[CW-1:0];
        bit_buf   <= bit_buf >> code_width;
        bit_count <= bit_count - 6'(code_width);
      end

      if (cmd.take) begin
        unique case (phase)
          lzwd_pkg::PH_FIRST: begin
            prev_code  <= code;
            first_char <= code[7:0];
            phase      <= lzwd_pkg::PH_NORMAL;
          end
          lzwd_pkg::PH_AFTER_RESTART: begin
            prev_code  <= code;
            first_char <= code[7:0];
            phase      <= lzwd_pkg::PH_NORMAL;
            if (emitted_done) begin
              phase <= lzwd_pkg::PH_DONE;
            end else if (!push_ok) begin
              err   <= 1'b1;
              phase <= lzwd_pkg::PH_DONE;
            end else begin
              q_count <= q_count + QCW'(1);
              emitted <= emitted + 16'd1;
              if (emitted + 16'd1 >= output_length) phase <= lzwd_pkg::PH_DONE;
            end
          end
          lzwd_pkg::PH_NORMAL: begin
            if (emitted_done || code_is_end) begin
              phase <= lzwd_pkg::PH_DONE;
            end else if (code_is_restart) begin
              code_width <= lzwd_pkg::START_WIDTH;
              next_code  <= lzwd_pkg::NEXT_RESTART;
              phase      <= lzwd_pkg::PH_AFTER_RESTART;
            end else begin
              kw         <= 17'(code) >= next_code;
              start_code <= (17'(code) >= next_code) ? prev_code : code;
              sel_start  <= 1'b1;
              steps      <= '0;
            end
          end
          lzwd_pkg::PH_DONE: begin
          end
          default: begin
          end
        endcase
      end

      if (cmd.cnt_step) begin
        steps     <= steps + SW'(1);
        sel_start <= 1'b0;
      end

      if (cmd.size) begin
        root <= cur[7:0];
        over <= 18'(steps) > 18'(EXPANSION_LIMIT);
        len  <= len_c;
        n    <= n_c;
        tail <= qwrap(18'(q_head), 18'(q_count));
      end

      if (cmd.fit) begin
        if (!st.fit_ok) begin
          err   <= 1'b1;
          phase <= lzwd_pkg::PH_DONE;
        end else begin
          sel_start <= 1'b1;
          pos       <= steps;
        end
      end

      // walk the chain again; each suffix is written in the next cycle
      if (cmd.fill_step && (pos != '0)) begin
        wr_pend   <= 18'(pos) < 18'(n);
        wr_pos    <= pos;
        pos       <= pos - SW'(1);
        sel_start <= 1'b0;
      end

      if (cmd.update) begin
        q_count <= q_count + QCW'(n);
        emitted <= emitted + n;
        if ((next_code > ((17'd1 << code_width) - 17'd2)) && (32'(code_width) < CW)) begin
          code_width <= code_width + 5'd1;
        end
        if (next_code < lzwd_pkg::NEXT_CAP) next_code <= next_code + 17'd1;
        prev_code  <= code;
        first_char <= root;
        if (emitted + n >= output_length) phase <= lzwd_pkg::PH_DONE;
      end

      if (cmd.emit_status) begin
        out_valid       <= 1'b1;
        out_byte        <= 8'd0;
        has_byte        <= 1'b0;
        last_of_run     <= 1'b1;
        finished        <= phase == lzwd_pkg::PH_DONE;
        expansion_error <= err;
      end

      if (cmd.emit_byte) begin
        out_valid       <= 1'b1;
        out_byte        <= q_rd;
        has_byte        <= 1'b1;
        last_of_run     <= st.emit_last;
        finished        <= phase == lzwd_pkg::PH_DONE;
        expansion_error <= err;
        q_head          <= qwrap(18'(q_head), 18'd1);
        q_count         <= q_count - QCW'(1);
        k               <= k + KW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    18'(q_count) <= 18'(STACK_DEPTH))
    else $error("queue fill exceeds depth");

  a_qwrite_excl: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> !(cmd.root_wr || cmd.kw_wr || cmd.take))
    else $error("suffix write collides with another queue write");

  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_byte |-> (q_count != '0) && out_free)
    else $error("byte beat from empty queue or into a full output register");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (code_width >= lzwd_pkg::START_WIDTH) && (32'(code_width) <= CW))
    else $error("code width out of range");
`endif

endmodule
